// File: src/incpi_pkg.sv
// Shared constants and handoff types for the incremental PI controller.
`default_nettype none

package incpi_pkg;

    // Sample width default and fixed field widths
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int GAIN_W          = 15;
    localparam int LIM_W           = 11;
    localparam int DRIVE_W         = 8;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;

    localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG_GAIN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWER_LIMIT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UPPER_LIMIT = 2'd3;

    localparam logic signed [LIM_W-1:0] LOWER_LIMIT_RST = -11'sd1000;
    localparam logic signed [LIM_W-1:0] UPPER_LIMIT_RST = 11'sd1000;

    // Increment / 100: saturate beyond any reachable clamp window, else reciprocal multiply
    localparam int QIN_W          = 19;
    localparam int QSAT_LIMIT     = 409600;
    localparam int QSAT_MAG       = 4096;
    localparam int QMAG_W         = 13;
    localparam int QUOT_W         = 14;
    localparam int RECIP100       = 335545;
    localparam int RECIP100_SHIFT = 25;

    // Accumulator sum width: 11-bit output plus 14-bit increment
    localparam int ACC_W = 15;

    // Control value / 10 by reciprocal multiply
    localparam int RECIP10       = 1639;
    localparam int RECIP10_SHIFT = 14;
    localparam int DQ_W          = 8;
    localparam int DRIVE_MIN     = 20;

    typedef struct packed {
        logic                     valid;
        logic signed [QUOT_W-1:0] quot;
    } incpi_quot_t;

    typedef struct packed {
        logic                    valid;
        logic signed [LIM_W-1:0] value;
    } incpi_acc_t;

endpackage

`default_nettype wire

// File: src/incpi_if.sv
// Channel interfaces for samples in and drive results out.
`default_nettype none

interface incpi_smp_if #(
    parameter int SAMPLE_BITS = incpi_pkg::SAMPLE_BITS_DEF
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] setpoint;
    logic [SAMPLE_BITS-1:0] measured;

    modport source (output valid, output setpoint, output measured, input ready);
    modport sink   (input valid, input setpoint, input measured, output ready);
endinterface

interface incpi_res_if;
    logic                                    valid;
    logic                                    ready;
    logic signed [incpi_pkg::DRIVE_W-1:0]    drive;
    logic signed [incpi_pkg::LIM_W-1:0]      control_value;

    modport source (output valid, output drive, output control_value, input ready);
    modport sink   (input valid, input drive, input control_value, output ready);
endinterface

`default_nettype wire

// File: src/incremental_pi_controller_top.sv
// Top level of the incremental PI controller: config registers and pipeline.
//
//  channel   dir   handshake            payload
//  sample    in    valid/ready          setpoint, measured (SAMPLE_BITS unsigned)
//  result    out   valid/ready          drive (8 signed), control_value (11 signed)
//  cfg       in    cfg_we               cfg_index (2), cfg_data (15)
//
//  One word per cycle sustained while result.ready stays high.
//  The stored output feeds back only through the accumulator stage, which closes the loop in its own register.
//  Reset sets gains to 0, limits to -1000/1000 and the stored error and output to 0.
//  Each stage holds while the next is full; sample.ready drops only when the sample
//  register is full and cannot advance.
`default_nettype none

module incremental_pi_controller_top #(
    parameter int SAMPLE_BITS = incpi_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [incpi_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [incpi_pkg::CFG_DATA_W-1:0]    cfg_data,
    incpi_smp_if.sink                                sample,
    incpi_res_if.source                              result
);

    logic [incpi_pkg::GAIN_W-1:0]          kp_reg, kp_next;
    logic [incpi_pkg::GAIN_W-1:0]          ki_reg, ki_next;
    logic signed [incpi_pkg::LIM_W-1:0]    lo_reg, lo_next;
    logic signed [incpi_pkg::LIM_W-1:0]    hi_reg, hi_next;

    incpi_pkg::incpi_quot_t                quot;
    incpi_pkg::incpi_acc_t                 acc;
    logic                                  take_acc;
    logic                                  take_out;

    always_comb
    begin
        kp_next = kp_reg;
        ki_next = ki_reg;
        lo_next = lo_reg;
        hi_next = hi_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                incpi_pkg::CFG_PROP_GAIN:   kp_next = cfg_data[incpi_pkg::GAIN_W-1:0];
                incpi_pkg::CFG_INTEG_GAIN:  ki_next = cfg_data[incpi_pkg::GAIN_W-1:0];
                incpi_pkg::CFG_LOWER_LIMIT: lo_next = $signed(cfg_data[incpi_pkg::LIM_W-1:0]);
                incpi_pkg::CFG_UPPER_LIMIT: hi_next = $signed(cfg_data[incpi_pkg::LIM_W-1:0]);
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg <= '0;
            ki_reg <= '0;
            lo_reg <= incpi_pkg::LOWER_LIMIT_RST;
            hi_reg <= incpi_pkg::UPPER_LIMIT_RST;
        end
        else
        begin
            kp_reg <= kp_next;
            ki_reg <= ki_next;
            lo_reg <= lo_next;
            hi_reg <= hi_next;
        end
    end

    incpi_gain #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_gain (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample     (sample),
        .prop_gain  (kp_reg),
        .integ_gain (ki_reg),
        .take       (take_acc),
        .quot_out   (quot)
    );

    incpi_accum u_accum (
        .clk         (clk),
        .rst_n       (rst_n),
        .quot_in     (quot),
        .lower_limit (lo_reg),
        .upper_limit (hi_reg),
        .take_down   (take_out),
        .take        (take_acc),
        .acc_out     (acc)
    );

    incpi_drive u_drive (
        .clk    (clk),
        .rst_n  (rst_n),
        .acc_in (acc),
        .take   (take_out),
        .result (result)
    );

endmodule

`default_nettype wire

// File: src/incpi_gain.sv
// Sample register, error terms, gain products and increment quotient stages.
`default_nettype none

module incpi_gain #(
    parameter int SAMPLE_BITS = incpi_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    incpi_smp_if.sink                             sample,
    input  wire logic [incpi_pkg::GAIN_W-1:0]     prop_gain,
    input  wire logic [incpi_pkg::GAIN_W-1:0]     integ_gain,
    input  wire logic                             take,
    output incpi_pkg::incpi_quot_t                quot_out
);

    localparam int EW = SAMPLE_BITS + 1;
    localparam int DW = SAMPLE_BITS + 2;
    localparam int PW = DW + incpi_pkg::GAIN_W;
    localparam int SW = PW + 1;
    localparam int QP = 2 * incpi_pkg::QIN_W;

    // Stage valids
    logic v0_reg, v1_reg, v2_reg, v3_reg;
    logic v0_next, v1_next, v2_next, v3_next;
    logic en0, en1, en2, en3;

    // Stage 0: raw samples
    logic [SAMPLE_BITS-1:0] sp_reg, ms_reg;

    // Stage 1: products
    logic signed [EW-1:0] err;
    logic signed [DW-1:0] derr;
    logic signed [EW-1:0] prev_err_reg;
    logic signed [PW-1:0] prod_p_reg, prod_i_reg;
    logic signed [PW-1:0] prod_p_next, prod_i_next;

    // Stage 2: magnitude of the sum
    logic signed [SW-1:0]              sum;
    logic [SW-1:0]                     mag;
    logic                              neg_reg, sat_reg;
    logic                              neg_next, sat_next;
    logic [incpi_pkg::QIN_W-1:0]       mag_reg;

    // Stage 3: quotient
    logic [QP-1:0]                          qprod;
    logic [incpi_pkg::QMAG_W-1:0]           qmag;
    logic signed [incpi_pkg::QUOT_W-1:0]    qmag_s;
    logic signed [incpi_pkg::QUOT_W-1:0]    quot_reg, quot_next;

    assign en3 = v2_reg && (!v3_reg || take);
    assign en2 = v1_reg && (!v2_reg || en3);
    assign en1 = v0_reg && (!v1_reg || en2);
    assign en0 = sample.valid && (!v0_reg || en1);

    assign sample.ready = !v0_reg || en1;

    always_comb
    begin
        v0_next = en0 ? 1'b1 : (en1 ? 1'b0 : v0_reg);
        v1_next = en1 ? 1'b1 : (en2 ? 1'b0 : v1_reg);
        v2_next = en2 ? 1'b1 : (en3 ? 1'b0 : v2_reg);
        v3_next = en3 ? 1'b1 : (take ? 1'b0 : v3_reg);
    end

    always_comb
    begin
        err         = $signed({1'b0, sp_reg}) - $signed({1'b0, ms_reg});
        derr        = DW'(err) - DW'(prev_err_reg);
        prod_p_next = PW'($signed({1'b0, prop_gain})) * PW'(derr);
        prod_i_next = PW'($signed({1'b0, integ_gain})) * PW'(err);
    end

    // Past the saturation point the clamp cannot tell the quotient apart
    always_comb
    begin
        sum      = SW'(prod_p_reg) + SW'(prod_i_reg);
        neg_next = sum[SW-1];
        mag      = neg_next ? SW'(-sum) : SW'(sum);
        sat_next = mag >= SW'(incpi_pkg::QSAT_LIMIT);
    end

    always_comb
    begin
        qprod  = QP'(mag_reg) * QP'(incpi_pkg::RECIP100);
        qmag   = sat_reg ? incpi_pkg::QMAG_W'(incpi_pkg::QSAT_MAG)
                         : qprod[incpi_pkg::RECIP100_SHIFT +: incpi_pkg::QMAG_W];
        qmag_s = $signed({1'b0, qmag});
        quot_next = neg_reg ? -qmag_s : qmag_s;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg       <= 1'b0;
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
            prev_err_reg <= '0;
        end
        else
        begin
            v0_reg <= v0_next;
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            if (en1)
            begin
                prev_err_reg <= err;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en0)
        begin
            sp_reg <= sample.setpoint;
            ms_reg <= sample.measured;
        end
        if (en1)
        begin
            prod_p_reg <= prod_p_next;
            prod_i_reg <= prod_i_next;
        end
        if (en2)
        begin
            neg_reg <= neg_next;
            sat_reg <= sat_next;
            mag_reg <= mag[incpi_pkg::QIN_W-1:0];
        end
        if (en3)
        begin
            quot_reg <= quot_next;
        end
    end

    assign quot_out.valid = v3_reg;
    assign quot_out.quot  = quot_reg;

endmodule

`default_nettype wire

// File: src/incpi_accum.sv
// Accumulator stage: adds the increment to the last output and clamps it.
`default_nettype none

module incpi_accum (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire incpi_pkg::incpi_quot_t               quot_in,
    input  wire logic signed [incpi_pkg::LIM_W-1:0]   lower_limit,
    input  wire logic signed [incpi_pkg::LIM_W-1:0]   upper_limit,
    input  wire logic                                 take_down,
    output logic                                      take,
    output incpi_pkg::incpi_acc_t                     acc_out
);

    logic                                   v_reg, v_next;
    logic signed [incpi_pkg::LIM_W-1:0]     out_reg, out_next;
    logic signed [incpi_pkg::ACC_W-1:0]     sum;
    logic signed [incpi_pkg::ACC_W-1:0]     upper_clamped;

    assign take = quot_in.valid && (!v_reg || take_down);

    always_comb
    begin
        v_next = take ? 1'b1 : (take_down ? 1'b0 : v_reg);
    end

    // Upper clamp first, then lower: crossed limits settle on the lower one
    always_comb
    begin
        sum = incpi_pkg::ACC_W'(out_reg) + incpi_pkg::ACC_W'(quot_in.quot);
        upper_clamped = (sum > incpi_pkg::ACC_W'(upper_limit))
                      ? incpi_pkg::ACC_W'(upper_limit) : sum;
        out_next = (upper_clamped < incpi_pkg::ACC_W'(lower_limit))
                 ? lower_limit : upper_clamped[incpi_pkg::LIM_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg   <= 1'b0;
            out_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
            if (take)
            begin
                out_reg <= out_next;
            end
        end
    end

    assign acc_out.valid = v_reg;
    assign acc_out.value = out_reg;

    a_within_limits: assert property (@(posedge clk) disable iff (!rst_n)
        take && (lower_limit <= upper_limit) |=>
            (out_reg >= $past(lower_limit)) && (out_reg <= $past(upper_limit)))
        else $error("accumulated value outside limits");

    a_crossed_limits: assert property (@(posedge clk) disable iff (!rst_n)
        take && (lower_limit > upper_limit) |=> out_reg == $past(lower_limit))
        else $error("crossed limits did not settle on lower limit");

    a_take_fills: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> v_reg)
        else $error("accumulator empty after taking a word");

endmodule

`default_nettype wire

// File: src/incpi_drive.sv
// Result register: scales the control value to the drive word.
`default_nettype none

module incpi_drive (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire incpi_pkg::incpi_acc_t acc_in,
    output logic                      take,
    incpi_res_if.source               result
);

    localparam int MW = 2 * incpi_pkg::LIM_W;

    logic                                     valid_reg, valid_next;
    logic signed [incpi_pkg::DRIVE_W-1:0]     drive_reg, drive_next;
    logic signed [incpi_pkg::LIM_W-1:0]       ctrl_reg;
    logic                                     neg;
    logic [incpi_pkg::LIM_W-1:0]              mag;
    logic [MW-1:0]                            dprod;
    logic [incpi_pkg::DQ_W-1:0]               dq;
    logic signed [incpi_pkg::DRIVE_W-1:0]     dq_s;

    assign take = acc_in.valid && (!valid_reg || result.ready);

    always_comb
    begin
        valid_next = take ? 1'b1 : (result.ready ? 1'b0 : valid_reg);
    end

    // Lift small quotients to the minimum drive; a zero quotient goes positive
    always_comb
    begin
        neg   = acc_in.value[incpi_pkg::LIM_W-1];
        mag   = neg ? incpi_pkg::LIM_W'(-acc_in.value) : incpi_pkg::LIM_W'(acc_in.value);
        dprod = MW'(mag) * MW'(incpi_pkg::RECIP10);
        dq    = dprod[incpi_pkg::RECIP10_SHIFT +: incpi_pkg::DQ_W];
        dq_s  = $signed(dq);
        if (dq < incpi_pkg::DQ_W'(incpi_pkg::DRIVE_MIN))
        begin
            drive_next = (neg && (dq != '0))
                       ? -incpi_pkg::DRIVE_W'(incpi_pkg::DRIVE_MIN)
                       : incpi_pkg::DRIVE_W'(incpi_pkg::DRIVE_MIN);
        end
        else
        begin
            drive_next = neg ? -dq_s : dq_s;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            drive_reg <= drive_next;
            ctrl_reg  <= acc_in.value;
        end
    end

    assign result.valid         = valid_reg;
    assign result.drive         = drive_reg;
    assign result.control_value = ctrl_reg;

    a_drive_floor: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (drive_reg >= 8'sd20) || (drive_reg <= -8'sd20))
        else $error("drive magnitude below floor");

    a_small_negative: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && (ctrl_reg < 11'sd0) && (ctrl_reg > -11'sd10) |-> drive_reg == 8'sd20)
        else $error("zero quotient not lifted to positive floor");

    a_take_presents: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> valid_reg)
        else $error("result register empty after taking a word");

endmodule

`default_nettype wire

// File: verif/incremental_pi_controller_top_test.sv
// Self-checking testbench for the incremental PI controller: directed and random samples.
module incremental_pi_controller_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SB          = incpi_pkg::SAMPLE_BITS_DEF;
    localparam int SMAX        = (1 << SB) - 1;
    localparam int RAND_PHASES = 14;
    localparam int RAND_ITEMS  = 124;
    localparam int HOLD_CYCLES = 400;

    typedef struct {
        logic [SB-1:0] setpoint;
        logic [SB-1:0] measured;
    } sample_word_t;

    typedef struct {
        logic signed [incpi_pkg::DRIVE_W-1:0] drive;
        logic signed [incpi_pkg::LIM_W-1:0]   control_value;
    } drive_word_t;

    logic                             clk = 1'b0;
    logic                             rst_n;
    logic                             cfg_we;
    logic [incpi_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [incpi_pkg::CFG_DATA_W-1:0] cfg_data;

    incpi_smp_if #(.SAMPLE_BITS(SB)) smp ();
    incpi_res_if                     res ();

    incremental_pi_controller_top #(.SAMPLE_BITS(SB)) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample    (smp),
        .result    (res)
    );

    always #1 clk = ~clk;

    // Controller mirror: settings and stored state
    logic [incpi_pkg::GAIN_W-1:0]       kp_gain;
    logic [incpi_pkg::GAIN_W-1:0]       ki_gain;
    logic signed [incpi_pkg::LIM_W-1:0] lim_lo;
    logic signed [incpi_pkg::LIM_W-1:0] lim_hi;
    logic signed [SB:0]                 last_error;
    logic signed [incpi_pkg::LIM_W-1:0] last_output;

    sample_word_t samples_pending[$];
    drive_word_t  drive_words_due[$];

    int errors        = 0;
    int samples_taken = 0;
    int results_seen  = 0;
    int phases_run    = 0;
    int send_gap_max  = 0;
    int recv_gap_max  = 0;
    int send_wait     = 0;
    int recv_wait     = 0;
    int hold_asked    = 0;
    int hold_done     = 0;
    int hold_left     = 0;
    bit sample_took;
    bit result_took;

    function automatic void advance_controller(input logic [SB-1:0] sp,
                                               input logic [SB-1:0] ms);
        longint      sp_l, ms_l, err, kp_l, ki_l, lo_l, hi_l, incr, ctrl, quot;
        drive_word_t word;
        sp_l = sp;
        ms_l = ms;
        kp_l = kp_gain;
        ki_l = ki_gain;
        lo_l = lim_lo;
        hi_l = lim_hi;
        err  = sp_l - ms_l;
        incr = kp_l * (err - longint'(last_error)) + ki_l * err;
        ctrl = longint'(last_output) + incr / 100;
        // upper clamp first, so crossed limits settle on the lower one
        if (ctrl > hi_l) ctrl = hi_l;
        if (ctrl < lo_l) ctrl = lo_l;
        last_error  = err[SB:0];
        last_output = ctrl[incpi_pkg::LIM_W-1:0];
        quot = ctrl / 10;
        // lift the dead band; a zero quotient goes positive
        if (quot >= 0 && quot < incpi_pkg::DRIVE_MIN)
            quot = incpi_pkg::DRIVE_MIN;
        else if (quot <= 0 && quot > -incpi_pkg::DRIVE_MIN)
            quot = -incpi_pkg::DRIVE_MIN;
        word.drive         = quot[incpi_pkg::DRIVE_W-1:0];
        word.control_value = ctrl[incpi_pkg::LIM_W-1:0];
        drive_words_due.push_back(word);
    endfunction

    function automatic int clip_sample(input int v);
        if (v < 0) return 0;
        if (v > SMAX) return SMAX;
        return v;
    endfunction

    function automatic logic [incpi_pkg::CFG_DATA_W-1:0] pick_gain();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return incpi_pkg::CFG_DATA_W'($urandom_range(1, 20));
            2:       return incpi_pkg::CFG_DATA_W'($urandom_range(0, 400));
            3:       return incpi_pkg::CFG_DATA_W'($urandom_range(2000, 32767));
            default: return '1;
        endcase
    endfunction

    task automatic set_reg(input logic [incpi_pkg::CFG_IDX_W-1:0] idx,
                           input logic [incpi_pkg::CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            incpi_pkg::CFG_PROP_GAIN:   kp_gain = data[incpi_pkg::GAIN_W-1:0];
            incpi_pkg::CFG_INTEG_GAIN:  ki_gain = data[incpi_pkg::GAIN_W-1:0];
            incpi_pkg::CFG_LOWER_LIMIT: lim_lo  = data[incpi_pkg::LIM_W-1:0];
            incpi_pkg::CFG_UPPER_LIMIT: lim_hi  = data[incpi_pkg::LIM_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Limits only use the low bits; scramble the rest of the data word
    task automatic write_limits(input int lo, input int hi);
        logic [incpi_pkg::CFG_DATA_W-1:0] d;
        d = incpi_pkg::CFG_DATA_W'($urandom);
        d[incpi_pkg::LIM_W-1:0] = lo[incpi_pkg::LIM_W-1:0];
        set_reg(incpi_pkg::CFG_LOWER_LIMIT, d);
        d = incpi_pkg::CFG_DATA_W'($urandom);
        d[incpi_pkg::LIM_W-1:0] = hi[incpi_pkg::LIM_W-1:0];
        set_reg(incpi_pkg::CFG_UPPER_LIMIT, d);
    endtask

    task automatic queue_sample(input int sp, input int ms);
        sample_word_t w;
        w.setpoint = sp[SB-1:0];
        w.measured = ms[SB-1:0];
        samples_pending.push_back(w);
    endtask

    // Hold until every queued sample has gone in and every word has come out
    task automatic wait_drained();
        do
            @(posedge clk);
        while (samples_pending.size() != 0 || smp.valid || drive_words_due.size() != 0);
        phases_run++;
    endtask

    // Scoreboard: check the result word first, then predict from the sample word
    always @(posedge clk)
    begin
        drive_word_t due;
        if (!rst_n)
        begin
            sample_took <= 1'b0;
            result_took <= 1'b0;
            last_error  = '0;
            last_output = '0;
        end
        else
        begin
            sample_took <= smp.valid && smp.ready;
            result_took <= res.valid && res.ready;
            if (res.valid && res.ready)
            begin
                results_seen++;
                if (drive_words_due.size() == 0)
                begin
                    errors++;
                    $display("%0t unexpected word: expected none, got drive %0d value %0d",
                             $time, res.drive, res.control_value);
                end
                else
                begin
                    due = drive_words_due.pop_front();
                    if (res.drive !== due.drive)
                    begin
                        errors++;
                        $display("%0t drive mismatch: expected %0d, got %0d",
                                 $time, due.drive, res.drive);
                    end
                    if (res.control_value !== due.control_value)
                    begin
                        errors++;
                        $display("%0t control_value mismatch: expected %0d, got %0d",
                                 $time, due.control_value, res.control_value);
                    end
                end
            end
            if (smp.valid && smp.ready)
            begin
                samples_taken++;
                advance_controller(smp.setpoint, smp.measured);
            end
        end
    end

    // Sample driver
    always @(negedge clk)
    begin
        sample_word_t w;
        if (!rst_n)
        begin
            smp.valid    <= 1'b0;
            smp.setpoint <= '0;
            smp.measured <= '0;
        end
        else if (!smp.valid || sample_took)
        begin
            if (send_wait > 0)
            begin
                smp.valid <= 1'b0;
                send_wait--;
            end
            else if (samples_pending.size() != 0)
            begin
                w = samples_pending.pop_front();
                smp.valid    <= 1'b1;
                smp.setpoint <= w.setpoint;
                smp.measured <= w.measured;
                send_wait = $urandom_range(0, send_gap_max);
            end
            else
                smp.valid <= 1'b0;
        end
    end

    // Result receiver
    always @(negedge clk)
    begin
        if (!rst_n)
            res.ready <= 1'b0;
        else
        begin
            if (hold_asked != hold_done)
            begin
                hold_done = hold_asked;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                res.ready <= 1'b0;
                hold_left--;
            end
            else if (result_took)
            begin
                recv_wait = $urandom_range(0, recv_gap_max);
                res.ready <= (recv_wait == 0);
                if (recv_wait > 0)
                    recv_wait--;
            end
            else if (recv_wait > 0)
            begin
                res.ready <= 1'b0;
                recv_wait--;
            end
            else
                res.ready <= 1'b1;
        end
    end

    initial
    begin
        int track_sp;
        int track_ms;
        int sp_i;
        int ms_i;
        int pick;
        int lo;
        int hi;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        kp_gain      = '0;
        ki_gain      = '0;
        lim_lo       = incpi_pkg::LOWER_LIMIT_RST;
        lim_hi       = incpi_pkg::UPPER_LIMIT_RST;
        track_sp     = SMAX / 2;
        track_ms     = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset settings: zero gains leave the value at zero, drive lifts to +20
        send_gap_max = 3;
        recv_gap_max = 3;
        queue_sample(0, 0);
        queue_sample(SMAX, 0);
        queue_sample(0, SMAX);
        queue_sample(SMAX, SMAX);
        wait_drained();

        // Full gains, limits at the 11-bit extremes
        set_reg(incpi_pkg::CFG_PROP_GAIN, '1);
        set_reg(incpi_pkg::CFG_INTEG_GAIN, '1);
        write_limits(-1024, 1023);
        queue_sample(SMAX, 0);
        queue_sample(0, SMAX);
        queue_sample(0, 0);
        wait_drained();

        // Negative window: small negatives go to -20, a zero quotient to +20
        set_reg(incpi_pkg::CFG_PROP_GAIN, '0);
        set_reg(incpi_pkg::CFG_INTEG_GAIN, incpi_pkg::CFG_DATA_W'(100));
        write_limits(-150, -1);
        queue_sample(0, SMAX);
        queue_sample(SMAX, 0);
        queue_sample(0, 500);
        wait_drained();

        // Crossed limits settle on the lower one
        write_limits(500, -500);
        queue_sample(SMAX, 0);
        queue_sample(0, SMAX);
        wait_drained();

        // Proportional term alone
        set_reg(incpi_pkg::CFG_PROP_GAIN, incpi_pkg::CFG_DATA_W'(1));
        set_reg(incpi_pkg::CFG_INTEG_GAIN, '0);
        write_limits(-1000, 1000);
        queue_sample(1000, 0);
        queue_sample(0, 0);
        queue_sample(40000, 0);
        queue_sample(0, 40000);
        wait_drained();

        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            set_reg(incpi_pkg::CFG_PROP_GAIN, pick_gain());
            set_reg(incpi_pkg::CFG_INTEG_GAIN, pick_gain());
            case ($urandom_range(0, 5))
                0:
                begin
                    lo = -1000;
                    hi = 1000;
                end
                1:
                begin
                    lo = int'($urandom_range(0, 1000)) - 1000;
                    hi = int'($urandom_range(0, 1000));
                end
                2:
                begin
                    lo = int'($urandom_range(0, 2047)) - 1024;
                    hi = int'($urandom_range(0, 2047)) - 1024;
                end
                3:
                begin
                    lo = int'($urandom_range(0, 400)) - 200;
                    hi = lo + int'($urandom_range(0, 60));
                end
                4:
                begin
                    lo = -1024;
                    hi = 1023;
                end
                default:
                begin
                    lo = int'($urandom_range(1, 1000));
                    hi = -lo;
                end
            endcase
            write_limits(lo, hi);

            case (ph % 4)
                0:
                begin
                    send_gap_max = 0;
                    recv_gap_max = 0;
                end
                1:
                begin
                    send_gap_max = 10;
                    recv_gap_max = 2;
                end
                2:
                begin
                    send_gap_max = 1;
                    recv_gap_max = 10;
                end
                default:
                begin
                    send_gap_max = 10;
                    recv_gap_max = 10;
                end
            endcase
            // long receiver hold-off with the sender flat out, to back the pipeline up
            if (ph == 5 || ph == 11)
            begin
                send_gap_max = 0;
                recv_gap_max = 3;
                hold_asked++;
            end

            for (int n = 0; n < RAND_ITEMS; n++)
            begin
                pick = $urandom_range(0, 19);
                if (pick < 12)
                begin
                    // setpoint held in runs, measurement chasing it with noise
                    if ($urandom_range(0, 15) == 0)
                        track_sp = $urandom_range(0, SMAX);
                    track_ms = clip_sample(track_ms + (track_sp - track_ms) / 8
                                           + int'($urandom_range(0, 40)) - 20);
                    queue_sample(track_sp, track_ms);
                end
                else if (pick < 17)
                begin
                    sp_i = $urandom_range(0, SMAX);
                    ms_i = clip_sample(sp_i + int'($urandom_range(0, 200)) - 100);
                    queue_sample(sp_i, ms_i);
                end
                else
                    queue_sample($urandom_range(0, SMAX), $urandom_range(0, SMAX));
            end
            wait_drained();
        end

        repeat (20) @(posedge clk);
        $display("Run covered %0d samples and %0d drive words over %0d setting phases,",
                 samples_taken, results_seen, phases_run);
        $display("with %0d receiver hold-offs and %0d mismatches.", hold_done, errors);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
